@@ hdl/jsu_pkg.sv @@
// Package for the JSON string unescaper: types, constants and helper functions.
// Used by every module of the block; depends on nothing else.

package jsu_pkg;

   // Default depth of the queue between front and back.
   localparam int QUEUE_DEPTH_DEF = 4;

   // Most result bytes one request can cause: a held surrogate plus a 3-byte code.
   localparam int MAX_BYTES = 6;

   // Status codes of a result.
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_TRUNCATED   = 2'd1;
   localparam logic [1:0] ST_BAD_UNICODE = 2'd2;
   localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

   // Characters the parser looks at.
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_U         = 8'h75;

   // Code point ranges.
   localparam logic [15:0] CP_HIGH_MIN = 16'hD800;
   localparam logic [15:0] CP_HIGH_MAX = 16'hDBFF;
   localparam logic [15:0] CP_LOW_MIN  = 16'hDC00;
   localparam logic [15:0] CP_LOW_MAX  = 16'hDFFF;
   localparam logic [15:0] CP_MAX_1B   = 16'h007F;
   localparam logic [15:0] CP_MAX_2B   = 16'h07FF;
   localparam logic [20:0] CP_SUPP_BASE = 21'h10000;

   // Parser phases.
   typedef enum logic [2:0] {
      PH_NORMAL,
      PH_ESC,
      PH_HEX,
      PH_HELD,
      PH_HELD_ESC,
      PH_LOW_HEX
   } phase_type;

   // A UTF-8 sequence of up to four bytes, first byte at index 0.
   typedef struct packed {
      logic [2:0]      count;
      logic [3:0][7:0] bytes;
   } utf_seq_type;

   // All result bytes caused by one request, as queued for the back end.
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [2:0]                count;
      logic                      eos;
      logic [1:0]                status;
   } burst_type;

   // Hex digit value in the low four bits; bit 4 flags a non-hex character.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b0, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // Single-character escapes; bit 8 flags a letter that is not one of them.
   function automatic logic [8:0] esc_map(input logic [7:0] c);
      logic [8:0] r;
      r = 9'h100;
      if (c == CH_QUOTE || c == CH_BACKSLASH || c == CH_SLASH) begin
         r = {1'b0, c};
      end else if (c == CH_B) begin
         r = 9'h008;
      end else if (c == CH_F) begin
         r = 9'h00C;
      end else if (c == CH_N) begin
         r = 9'h00A;
      end else if (c == CH_R) begin
         r = 9'h00D;
      end else if (c == CH_T) begin
         r = 9'h009;
      end
      return r;
   endfunction

   function automatic logic is_high(input logic [15:0] cp);
      return (cp >= CP_HIGH_MIN) && (cp <= CP_HIGH_MAX);
   endfunction

   function automatic logic is_low(input logic [15:0] cp);
      return (cp >= CP_LOW_MIN) && (cp <= CP_LOW_MAX);
   endfunction

   // One byte as a sequence.
   function automatic utf_seq_type seq_byte(input logic [7:0] b);
      utf_seq_type s;
      s.count = 3'd1;
      s.bytes = '0;
      s.bytes[0] = b;
      return s;
   endfunction

   // UTF-8 encoding of a code point from the basic plane.
   function automatic utf_seq_type enc_cp16(input logic [15:0] cp);
      utf_seq_type s;
      s.bytes = '0;
      if (cp <= CP_MAX_1B) begin
         s.count = 3'd1;
         s.bytes[0] = cp[7:0];
      end else if (cp <= CP_MAX_2B) begin
         s.count = 3'd2;
         s.bytes[0] = {3'b110, cp[10:6]};
         s.bytes[1] = {2'b10, cp[5:0]};
      end else begin
         s.count = 3'd3;
         s.bytes[0] = {4'b1110, cp[15:12]};
         s.bytes[1] = {2'b10, cp[11:6]};
         s.bytes[2] = {2'b10, cp[5:0]};
      end
      return s;
   endfunction

   // Four-byte encoding of a surrogate pair; both halves are known to be in range.
   function automatic utf_seq_type enc_pair(input logic [15:0] hi, input logic [15:0] lo);
      utf_seq_type s;
      logic [20:0] cp;
      cp = CP_SUPP_BASE + {1'b0, hi[9:0], lo[9:0]};
      s.count = 3'd4;
      s.bytes[0] = {5'b11110, cp[20:18]};
      s.bytes[1] = {2'b10, cp[17:12]};
      s.bytes[2] = {2'b10, cp[11:6]};
      s.bytes[3] = {2'b10, cp[5:0]};
      return s;
   endfunction

endpackage

@@ hdl/jsu_if.sv @@
// Channel interfaces of the JSON string unescaper: request and response.
// Each carries valid, ready and the payload; no dependencies.

interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last;

   modport source (output valid, output in_byte, output last, input ready);
   modport sink (input valid, input in_byte, input last, output ready);
endinterface

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       end_of_string;
   logic [1:0] status;

   modport source (output valid, output out_byte, output end_of_string, output status,
                   input ready);
   modport sink (input valid, input out_byte, input end_of_string, input status,
                 output ready);
endinterface

@@ hdl/jsu_front.sv @@
// Front end: accepts request bytes, runs the escape parser and builds at most one burst
// of result bytes per request. Depends on jsu_pkg and jsu_req_if.

module jsu_front (
   input  logic              clock,
   input  logic              reset,
   jsu_req_if.sink           req_chan,
   input  logic              queue_full,
   output logic              push,
   output jsu_pkg::burst_type push_burst
);

   jsu_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  hex_count_ff, hex_count_in;
   logic [15:0] code_accum_ff, code_accum_in;
   logic [15:0] held_high_ff, held_high_in;
   logic        drop_rest_ff, drop_rest_in;

   logic        accept;
   logic [7:0]  c;
   logic        last;
   logic [4:0]  hex;
   logic        hex_ok;
   logic [15:0] accum_next;
   logic [2:0]  count_next;
   logic        code_done;
   logic [8:0]  esc;
   logic        esc_simple;
   logic        is_bs;
   logic        is_u;
   logic        esc_err;
   logic        err;

   // Request handshake.
   assign req_chan.ready = !queue_full;
   assign accept = req_chan.valid && req_chan.ready;
   assign c = req_chan.in_byte;
   assign last = req_chan.last;

   // Shared decoding of the current byte.
   assign hex = jsu_pkg::hex_digit(c);
   assign hex_ok = !hex[4];
   assign accum_next = {code_accum_ff[11:0], hex[3:0]};
   assign count_next = hex_count_ff + 3'd1;
   assign code_done = count_next[2];
   assign esc = jsu_pkg::esc_map(c);
   assign esc_simple = !esc[8];
   assign is_bs = (c == jsu_pkg::CH_BACKSLASH);
   assign is_u = (c == jsu_pkg::CH_U);
   assign esc_err = !esc_simple && (!is_u || last);

   // Whether this byte ends the string with an error result.
   always_comb begin
      err = 1'b0;
      if (!drop_rest_ff) begin
         unique case (phase_ff)
            jsu_pkg::PH_ESC:      err = esc_err;
            jsu_pkg::PH_HEX:      err = !hex_ok || (!code_done && last);
            jsu_pkg::PH_HELD:     err = is_bs && last;
            jsu_pkg::PH_HELD_ESC: err = !(is_u && !last) && esc_err;
            jsu_pkg::PH_LOW_HEX:  err = !hex_ok || (!code_done && last);
            default:              err = is_bs && last;
         endcase
      end
   end

   // Next state of the parser.
   always_comb begin
      phase_in = phase_ff;
      hex_count_in = hex_count_ff;
      code_accum_in = code_accum_ff;
      held_high_in = held_high_ff;
      drop_rest_in = drop_rest_ff;
      if (drop_rest_ff) begin
         if (last) begin
            phase_in = jsu_pkg::PH_NORMAL;
            hex_count_in = '0;
            code_accum_in = '0;
            held_high_in = '0;
            drop_rest_in = 1'b0;
         end
      end else if (err || last) begin
         phase_in = jsu_pkg::PH_NORMAL;
         hex_count_in = '0;
         code_accum_in = '0;
         held_high_in = '0;
         drop_rest_in = err && !last;
      end else begin
         unique case (phase_ff)
            jsu_pkg::PH_ESC: begin
               if (is_u) begin
                  phase_in = jsu_pkg::PH_HEX;
                  hex_count_in = '0;
                  code_accum_in = '0;
               end else begin
                  phase_in = jsu_pkg::PH_NORMAL;
               end
            end
            jsu_pkg::PH_HEX: begin
               code_accum_in = accum_next;
               hex_count_in = count_next;
               if (code_done) begin
                  if (jsu_pkg::is_high(accum_next)) begin
                     held_high_in = accum_next;
                     phase_in = jsu_pkg::PH_HELD;
                  end else begin
                     phase_in = jsu_pkg::PH_NORMAL;
                  end
               end
            end
            jsu_pkg::PH_HELD: begin
               phase_in = is_bs ? jsu_pkg::PH_HELD_ESC : jsu_pkg::PH_NORMAL;
            end
            jsu_pkg::PH_HELD_ESC: begin
               if (is_u) begin
                  phase_in = jsu_pkg::PH_LOW_HEX;
                  hex_count_in = '0;
                  code_accum_in = '0;
               end else begin
                  phase_in = jsu_pkg::PH_NORMAL;
               end
            end
            jsu_pkg::PH_LOW_HEX: begin
               code_accum_in = accum_next;
               hex_count_in = count_next;
               if (code_done) begin
                  if (!jsu_pkg::is_low(accum_next) && jsu_pkg::is_high(accum_next)) begin
                     held_high_in = accum_next;
                     phase_in = jsu_pkg::PH_HELD;
                  end else begin
                     phase_in = jsu_pkg::PH_NORMAL;
                  end
               end
            end
            default: begin
               phase_in = is_bs ? jsu_pkg::PH_ESC : jsu_pkg::PH_NORMAL;
            end
         endcase
      end
   end

   // Result bytes of this request: an optional held surrogate, then the new part.
   always_comb begin
      logic                  held_out;
      logic                  new_en;
      jsu_pkg::utf_seq_type  held_seq;
      jsu_pkg::utf_seq_type  new_seq;
      logic [1:0]            st;

      held_out = 1'b0;
      new_en = 1'b0;
      held_seq = jsu_pkg::enc_cp16(held_high_ff);
      new_seq = jsu_pkg::seq_byte(c);
      st = jsu_pkg::ST_OK;

      if (!drop_rest_ff) begin
         unique case (phase_ff)
            jsu_pkg::PH_ESC: begin
               if (esc_simple) begin
                  new_en = 1'b1;
                  new_seq = jsu_pkg::seq_byte(esc[7:0]);
               end else if (esc_err) begin
                  new_en = 1'b1;
                  st = is_u ? jsu_pkg::ST_BAD_UNICODE : jsu_pkg::ST_UNSUPPORTED;
               end
            end
            jsu_pkg::PH_HEX: begin
               if (!hex_ok || (!code_done && last)) begin
                  new_en = 1'b1;
                  st = jsu_pkg::ST_BAD_UNICODE;
               end else if (code_done && !(jsu_pkg::is_high(accum_next) && !last)) begin
                  new_en = 1'b1;
                  new_seq = jsu_pkg::enc_cp16(accum_next);
               end
            end
            jsu_pkg::PH_HELD: begin
               if (!(is_bs && !last)) begin
                  held_out = 1'b1;
                  new_en = 1'b1;
                  if (is_bs) begin
                     st = jsu_pkg::ST_TRUNCATED;
                  end
               end
            end
            jsu_pkg::PH_HELD_ESC: begin
               if (!(is_u && !last)) begin
                  held_out = 1'b1;
                  if (esc_simple) begin
                     new_en = 1'b1;
                     new_seq = jsu_pkg::seq_byte(esc[7:0]);
                  end else begin
                     new_en = 1'b1;
                     st = is_u ? jsu_pkg::ST_BAD_UNICODE : jsu_pkg::ST_UNSUPPORTED;
                  end
               end
            end
            jsu_pkg::PH_LOW_HEX: begin
               if (!hex_ok || (!code_done && last)) begin
                  held_out = 1'b1;
                  new_en = 1'b1;
                  st = jsu_pkg::ST_BAD_UNICODE;
               end else if (code_done) begin
                  if (jsu_pkg::is_low(accum_next)) begin
                     new_en = 1'b1;
                     new_seq = jsu_pkg::enc_pair(held_high_ff, accum_next);
                  end else begin
                     held_out = 1'b1;
                     if (!(jsu_pkg::is_high(accum_next) && !last)) begin
                        new_en = 1'b1;
                        new_seq = jsu_pkg::enc_cp16(accum_next);
                     end
                  end
               end
            end
            default: begin
               // A backslash opens an escape and gives nothing, unless it ends the string.
               if (!(is_bs && !last)) begin
                  new_en = 1'b1;
                  if (is_bs) begin
                     st = jsu_pkg::ST_TRUNCATED;
                  end
               end
            end
         endcase
      end

      // An error result is a single zero byte.
      if (st != jsu_pkg::ST_OK) begin
         new_seq = jsu_pkg::seq_byte(8'h00);
      end
      if (!new_en) begin
         new_seq.count = 3'd0;
      end

      push_burst.bytes = '0;
      if (held_out) begin
         push_burst.bytes[0] = held_seq.bytes[0];
         push_burst.bytes[1] = held_seq.bytes[1];
         push_burst.bytes[2] = held_seq.bytes[2];
         push_burst.bytes[3] = new_seq.bytes[0];
         push_burst.bytes[4] = new_seq.bytes[1];
         push_burst.bytes[5] = new_seq.bytes[2];
         push_burst.count = 3'd3 + new_seq.count;
      end else begin
         push_burst.bytes[0] = new_seq.bytes[0];
         push_burst.bytes[1] = new_seq.bytes[1];
         push_burst.bytes[2] = new_seq.bytes[2];
         push_burst.bytes[3] = new_seq.bytes[3];
         push_burst.count = new_seq.count;
      end
      push_burst.eos = err || last;
      push_burst.status = st;
   end

   assign push = accept && (push_burst.count != 3'd0);

   // Parser registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jsu_pkg::PH_NORMAL;
         hex_count_ff <= '0;
         code_accum_ff <= '0;
         held_high_ff <= '0;
         drop_rest_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hex_count_ff <= hex_count_in;
         code_accum_ff <= code_accum_in;
         held_high_ff <= held_high_in;
         drop_rest_ff <= drop_rest_in;
      end
   end

endmodule

@@ hdl/jsu_queue.sv @@
// Short queue of result bursts between the front and back ends. Register-based,
// one write (unless full) and one read (unless empty) per cycle. Depends on jsu_pkg.

module jsu_queue #(
   parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  jsu_pkg::burst_type push_burst,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output jsu_pkg::burst_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   jsu_pkg::burst_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic do_push;
   logic do_pop;

   assign full = (fill_ff == CNT_FULL);
   assign not_empty = (fill_ff != '0);
   assign head = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && not_empty;

   // Pointer and fill count update with wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_burst;
      end
   end

endmodule

@@ hdl/jsu_back.sv @@
// Back end: takes bursts from the queue and sends their bytes one per cycle while the
// receiver is ready, through the response output register. Depends on jsu_pkg and jsu_rsp_if.

module jsu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_not_empty,
   input  jsu_pkg::burst_type queue_head,
   output logic               pop,
   jsu_rsp_if.source          rsp_chan
);

   jsu_pkg::burst_type cur_ff;
   logic               cur_valid_ff, cur_valid_in;
   logic [2:0]         idx_ff, idx_in;
   logic               out_valid_ff;
   logic [7:0]         out_byte_ff;
   logic               out_eos_ff;
   logic [1:0]         out_status_ff;

   logic out_free;
   logic take;
   logic cur_last;
   logic finish;

   // The output register is free when empty or being taken this cycle.
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign take = out_free && cur_valid_ff;
   assign cur_last = (idx_ff == cur_ff.count - 3'd1);
   assign finish = take && cur_last;
   assign pop = (!cur_valid_ff || finish) && queue_not_empty;

   // Current burst and byte index.
   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in = idx_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         idx_in = '0;
      end else if (finish) begin
         cur_valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= queue_head;
      end
   end

   // Response output register; status and end flag belong to the burst's final byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (take) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_byte_ff <= cur_ff.bytes[idx_ff];
         out_eos_ff <= cur_last && cur_ff.eos;
         out_status_ff <= cur_last ? cur_ff.status : jsu_pkg::ST_OK;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.out_byte = out_byte_ff;
   assign rsp_chan.end_of_string = out_eos_ff;
   assign rsp_chan.status = out_status_ff;

endmodule

@@ hdl/json_string_unescape_utf8_top.sv @@
// JSON string unescaper with UTF-8 output. Requests are taken one per cycle while the
// burst queue is not full, and result bytes leave one per cycle while the receiver is
// ready; a request that yields several bytes (up to six) sends them out one at a time,
// and the burst queue between parser and serializer sets how long input keeps flowing
// meanwhile. Synchronous reset clears the parser, queue and outputs.
// Depends on jsu_pkg, jsu_if, jsu_front, jsu_queue and jsu_back.

module json_string_unescape_utf8_top #(
   parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   jsu_req_if.sink   req_chan,
   jsu_rsp_if.source rsp_chan
);

   logic               queue_full;
   logic               push;
   jsu_pkg::burst_type push_burst;
   logic               pop;
   logic               queue_not_empty;
   jsu_pkg::burst_type queue_head;

   // Parser and burst builder.
   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_burst (push_burst)
   );

   // Burst queue.
   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_burst (push_burst),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (queue_not_empty),
      .head       (queue_head)
   );

   // Byte serializer and output register.
   jsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_head      (queue_head),
      .pop             (pop),
      .rsp_chan        (rsp_chan)
   );

endmodule

@@ test/tb_json_string_unescape_utf8_top.sv @@
`timescale 1ns / 100ps
// Testbench for the JSON string unescaper: a directed table, then random strings.
// Results are checked against a predictor kept here. Depends on jsu_pkg, jsu_if and the top.

module tb_json_string_unescape_utf8_top;
   import jsu_pkg::*;

   localparam int DIR_N        = 25;
   localparam int RANDOM_ITEMS = 285;
   localparam int QUIET_TAIL   = 40;
   localparam int HOLD_CYCLES  = 150;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 10;

   // The eight single-character escape letters.
   localparam logic [7:0][7:0] ESC_LETTERS = {CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B,
                                              CH_F, CH_N, CH_R, CH_T};

   typedef struct packed {
      logic [7:0] ch;
      logic       eos;
      logic [1:0] st;
   } utf8_byte_t;

   // One input byte; typed rows carry a result written into the table by hand.
   typedef struct packed {
      logic [7:0] ch;
      logic       lst;
      logic       typed;
      utf8_byte_t want;
   } raw_byte_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   jsu_req_if req_chan ();
   jsu_rsp_if rsp_chan ();

   json_string_unescape_utf8_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   raw_byte_t  stim [$];
   raw_byte_t  dir_rows [DIR_N];
   utf8_byte_t utf8_expect_q [$];
   utf8_byte_t step_q [$];

   int errors = 0;
   int n_req = 0;
   int n_checked = 0;
   int n_err_results = 0;
   int n_strings = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   bit hold_done = 1'b0;

   // Predictor state.
   phase_type   ph = PH_NORMAL;
   logic [2:0]  nhex = '0;
   logic [15:0] acc = '0;
   logic [15:0] held = '0;
   logic        dropping = 1'b0;
   logic        err_flag = 1'b0;

   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h61 + 8'd10;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h41 + 8'd10;
      end else begin
         return 5'h10;
      end
      return {1'b0, d[3:0]};
   endfunction

   // Bit 8 set means the letter is not a single-character escape.
   function automatic logic [8:0] esc_value(input logic [7:0] c);
      case (c)
         CH_QUOTE, CH_BACKSLASH, CH_SLASH: return {1'b0, c};
         CH_B: return 9'h008;   // backspace
         CH_F: return 9'h00C;   // form feed
         CH_N: return 9'h00A;   // line feed
         CH_R: return 9'h00D;   // carriage return
         CH_T: return 9'h009;   // tab
         default: return 9'h100;
      endcase
   endfunction

   function automatic void put_out(input logic [7:0] b, input logic [1:0] st);
      utf8_byte_t r;
      r.ch = b;
      r.eos = 1'b0;
      r.st = st;
      step_q.push_back(r);
   endfunction

   function automatic void raise_error(input logic [1:0] st);
      put_out(8'h00, st);
      err_flag = 1'b1;
   endfunction

   function automatic void clear_state();
      ph = PH_NORMAL;
      nhex = '0;
      acc = '0;
      held = '0;
      dropping = 1'b0;
   endfunction

   // UTF-8 encoding of a code point, 1 to 4 bytes.
   function automatic void put_code(input logic [20:0] cp);
      if (cp <= 21'h7F) begin
         put_out(cp[7:0], ST_OK);
      end else if (cp <= 21'h7FF) begin
         put_out({3'b110, cp[10:6]}, ST_OK);
         put_out({2'b10, cp[5:0]}, ST_OK);
      end else if (cp <= 21'hFFFF) begin
         put_out({4'b1110, cp[15:12]}, ST_OK);
         put_out({2'b10, cp[11:6]}, ST_OK);
         put_out({2'b10, cp[5:0]}, ST_OK);
      end else begin
         put_out({5'b11110, cp[20:18]}, ST_OK);
         put_out({2'b10, cp[17:12]}, ST_OK);
         put_out({2'b10, cp[11:6]}, ST_OK);
         put_out({2'b10, cp[5:0]}, ST_OK);
      end
   endfunction

   // A finished \u value: a high surrogate is held unless the string ends here.
   function automatic void end_code(input logic [15:0] cp, input logic lst);
      if (cp >= CP_HIGH_MIN && cp <= CP_HIGH_MAX && !lst) begin
         held = cp;
         ph = PH_HELD;
      end else begin
         put_code({5'b0, cp});
         ph = PH_NORMAL;
      end
   endfunction

   function automatic void do_escape(input logic [7:0] c, input logic lst);
      logic [8:0] m;
      m = esc_value(c);
      ph = PH_NORMAL;
      if (!m[8]) begin
         put_out(m[7:0], ST_OK);
      end else if (c == CH_U) begin
         if (lst) begin
            raise_error(ST_BAD_UNICODE);
         end else begin
            ph = PH_HEX;
            nhex = '0;
            acc = '0;
         end
      end else begin
         raise_error(ST_UNSUPPORTED);
      end
   endfunction

   function automatic void do_plain(input logic [7:0] c, input logic lst);
      if (c == CH_BACKSLASH) begin
         if (lst) raise_error(ST_TRUNCATED);
         else ph = PH_ESC;
      end else begin
         put_out(c, ST_OK);
         ph = PH_NORMAL;
      end
   endfunction

   // Works out the result bytes of one request into step_q.
   function automatic void unescape_step(input logic [7:0] c, input logic lst);
      logic [4:0] h;
      step_q.delete();
      err_flag = 1'b0;
      if (dropping) begin
         if (lst) clear_state();
         return;
      end
      case (ph)
         PH_ESC: do_escape(c, lst);
         PH_HEX: begin
            h = hex_nibble(c);
            if (h[4]) begin
               raise_error(ST_BAD_UNICODE);
            end else begin
               acc = {acc[11:0], h[3:0]};
               nhex = nhex + 3'd1;
               if (nhex >= 3'd4) end_code(acc, lst);
               else if (lst) raise_error(ST_BAD_UNICODE);
            end
         end
         PH_HELD: begin
            if (c == CH_BACKSLASH && !lst) begin
               ph = PH_HELD_ESC;
            end else begin
               put_code({5'b0, held});
               do_plain(c, lst);
            end
         end
         PH_HELD_ESC: begin
            if (c == CH_U && !lst) begin
               ph = PH_LOW_HEX;
               nhex = '0;
               acc = '0;
            end else begin
               put_code({5'b0, held});
               do_escape(c, lst);
            end
         end
         PH_LOW_HEX: begin
            h = hex_nibble(c);
            if (h[4]) begin
               put_code({5'b0, held});
               raise_error(ST_BAD_UNICODE);
            end else begin
               acc = {acc[11:0], h[3:0]};
               nhex = nhex + 3'd1;
               if (nhex >= 3'd4) begin
                  if (acc >= CP_LOW_MIN && acc <= CP_LOW_MAX) begin
                     put_code(CP_SUPP_BASE + {1'b0, held[9:0], acc[9:0]});
                     ph = PH_NORMAL;
                  end else begin
                     put_code({5'b0, held});
                     end_code(acc, lst);
                  end
               end else if (lst) begin
                  put_code({5'b0, held});
                  raise_error(ST_BAD_UNICODE);
               end
            end
         end
         default: do_plain(c, lst);
      endcase
      // An error or the last byte closes the string; an error mid-string drops the rest.
      if (err_flag || lst) begin
         clear_state();
         dropping = err_flag && !lst;
         if (step_q.size() > 0) step_q[$].eos = 1'b1;
      end
   endfunction

   // Stimulus building helpers.
   function automatic void push_ch(input logic [7:0] b);
      raw_byte_t r;
      r = '0;
      r.ch = b;
      stim.push_back(r);
   endfunction

   // Pushes the first n hex digits of cp, in either case.
   function automatic void push_digits(input logic [15:0] cp, input int n);
      logic [3:0] v;
      for (int i = 0; i < n; i++) begin
         v = cp[15 - 4 * i -: 4];
         if (v < 4'd10) push_ch(8'h30 + v);
         else if ($urandom_range(0, 1) == 0) push_ch(8'h61 + v - 8'd10);
         else push_ch(8'h41 + v - 8'd10);
      end
   endfunction

   function automatic void push_uesc(input logic [15:0] cp, input int n);
      push_ch(CH_BACKSLASH);
      push_ch(CH_U);
      push_digits(cp, n);
   endfunction

   function automatic logic [15:0] rand_high();
      return CP_HIGH_MIN | 16'($urandom_range(0, 1023));
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] b;
      logic [4:0] v;
      do begin
         b = 8'($urandom_range(0, 255));
         v = hex_nibble(b);
      end while (!v[4]);
      return b;
   endfunction

   // One random string: mostly well-formed segments, some broken ones.
   function automatic void gen_string();
      int nseg;
      int kind;
      logic [7:0] b;
      logic [8:0] m;
      logic [15:0] cp;
      nseg = $urandom_range(1, 6);
      for (int s = 0; s < nseg; s++) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            b = 8'($urandom_range(0, 255));
            push_ch(b);
            if (b == CH_BACKSLASH) push_ch(b);
         end else if (kind < 55) begin
            push_ch(CH_BACKSLASH);
            push_ch(ESC_LETTERS[3'($urandom_range(0, 7))]);
         end else if (kind < 70) begin
            case ($urandom_range(0, 3))
               0: cp = 16'($urandom_range(0, 16'h7F));
               1: cp = 16'($urandom_range(16'h80, 16'h7FF));
               2: cp = 16'($urandom_range(16'h800, 16'hFFFF));
               default: cp = 16'($urandom);
            endcase
            push_uesc(cp, 4);
         end else if (kind < 80) begin
            push_uesc(rand_high(), 4);
            push_uesc(CP_LOW_MIN | 16'($urandom_range(0, 1023)), 4);
         end else if (kind < 86) begin
            // Lone surrogate, high or low.
            push_uesc(CP_HIGH_MIN | 16'($urandom_range(0, 2047)), 4);
         end else if (kind < 90) begin
            push_uesc(rand_high(), 4);
            push_uesc(16'($urandom_range(0, 16'hD7FF)), 4);
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  push_ch(CH_BACKSLASH);
                  do begin
                     b = 8'($urandom_range(0, 255));
                     m = esc_value(b);
                  end while (!m[8] || b == CH_U);
                  push_ch(b);
               end
               1: begin
                  push_uesc(16'($urandom), $urandom_range(0, 3));
                  push_ch(non_hex_char());
               end
               2: begin
                  push_uesc(rand_high(), 4);
                  push_ch(CH_BACKSLASH);
                  push_ch(8'($urandom_range(0, 255)));
               end
               default: begin
                  push_uesc(rand_high(), 4);
                  push_uesc(16'($urandom), $urandom_range(0, 3));
                  push_ch(non_hex_char());
               end
            endcase
         end
      end
      // Now and then the string ends inside an escape.
      if ($urandom_range(0, 6) == 0) begin
         case ($urandom_range(0, 3))
            0: push_ch(CH_BACKSLASH);
            1: push_uesc(16'($urandom), $urandom_range(0, 3));
            2: begin
               push_uesc(rand_high(), 4);
               push_ch(CH_BACKSLASH);
            end
            default: begin
               push_uesc(rand_high(), 4);
               push_uesc(16'($urandom), $urandom_range(0, 3));
            end
         endcase
      end
      stim[$].lst = 1'b1;
   endfunction

   // Request and result monitor: predicts on each request, checks each result.
   always @(posedge clock) begin : monitor
      raw_byte_t  row;
      utf8_byte_t got;
      utf8_byte_t want;
      if (!reset) begin
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            row = stim[n_req];
            unescape_step(req_chan.in_byte, req_chan.last);
            if (row.typed) begin
               if (step_q.size() != 1 || step_q[0] != row.want) begin
                  $display("%t: table row %0d: expected byte %02h eos %0d status %0d,",
                           $time, n_req, row.want.ch, row.want.eos, row.want.st,
                           " predictor gives %0d results", step_q.size());
                  errors++;
               end
               utf8_expect_q.push_back(row.want);
            end else begin
               foreach (step_q[k]) utf8_expect_q.push_back(step_q[k]);
            end
            n_req++;
         end
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got.ch = rsp_chan.out_byte;
            got.eos = rsp_chan.end_of_string;
            got.st = rsp_chan.status;
            if (utf8_expect_q.size() == 0) begin
               $display("%t: unexpected result: byte %02h eos %0d status %0d",
                        $time, got.ch, got.eos, got.st);
               errors++;
            end else begin
               want = utf8_expect_q.pop_front();
               if (got.ch !== want.ch || got.eos !== want.eos || got.st !== want.st) begin
                  $display("%t: result mismatch: expected byte %02h eos %0d status %0d,",
                           $time, want.ch, want.eos, want.st,
                           " got byte %02h eos %0d status %0d",
                           got.ch, got.eos, got.st);
                  errors++;
               end
               n_checked++;
               if (want.st != ST_OK) n_err_results++;
            end
         end
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%t: nothing accepted for %0d cycles", $time, STALL_LIMIT);
         $display("tb_json_string_unescape_utf8_top: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result receiver: random stalls, one long hold-off, none in the last part.
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!quiet && !hold_done && n_req >= 80) begin
            hold_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end
   end

   // Main sequence: build the stimulus, reset, send every request, then drain.
   initial begin
      req_chan.valid <= 1'b0;
      req_chan.in_byte <= 8'h00;
      req_chan.last <= 1'b0;

      // Directed table: extremes, error codes, a held high surrogate and a pair.
      dir_rows = '{
         '{8'h41, 1'b0, 1'b1, '{8'h41, 1'b0, ST_OK}},
         '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b0, ST_OK}},
         '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, ST_OK}},
         '{CH_BACKSLASH, 1'b1, 1'b1, '{8'h00, 1'b1, ST_TRUNCATED}},
         '{CH_BACKSLASH, 1'b0, 1'b0, '0},
         '{8'h71, 1'b0, 1'b1, '{8'h00, 1'b1, ST_UNSUPPORTED}},
         '{8'h7A, 1'b1, 1'b0, '0},
         '{CH_BACKSLASH, 1'b0, 1'b0, '0},
         '{CH_U, 1'b0, 1'b0, '0},
         '{8'h67, 1'b0, 1'b1, '{8'h00, 1'b1, ST_BAD_UNICODE}},
         '{8'h00, 1'b1, 1'b0, '0},
         '{CH_BACKSLASH, 1'b0, 1'b0, '0},
         '{CH_U, 1'b0, 1'b0, '0},
         '{8'h44, 1'b0, 1'b0, '0},
         '{8'h62, 1'b0, 1'b0, '0},
         '{8'h46, 1'b0, 1'b0, '0},
         '{8'h66, 1'b0, 1'b0, '0},
         '{CH_BACKSLASH, 1'b0, 1'b0, '0},
         '{CH_U, 1'b0, 1'b0, '0},
         '{8'h44, 1'b0, 1'b0, '0},
         '{8'h43, 1'b0, 1'b0, '0},
         '{8'h30, 1'b0, 1'b0, '0},
         '{8'h30, 1'b1, 1'b0, '0},
         '{CH_BACKSLASH, 1'b0, 1'b0, '0},
         '{CH_U, 1'b1, 1'b1, '{8'h00, 1'b1, ST_BAD_UNICODE}}
      };
      for (int i = 0; i < DIR_N; i++) stim.push_back(dir_rows[i]);
      while (stim.size() < DIR_N + RANDOM_ITEMS) gen_string();
      foreach (stim[i]) if (stim[i].lst) n_strings++;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < stim.size(); i++) begin
         quiet = (i + QUIET_TAIL >= stim.size());
         if (!quiet && $urandom_range(0, 5) == 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         req_chan.valid <= 1'b1;
         req_chan.in_byte <= stim[i].ch;
         req_chan.last <= stim[i].lst;
         do @(posedge clock); while (req_chan.ready !== 1'b1);
      end
      req_chan.valid <= 1'b0;

      while (utf8_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests in %0d strings; checked %0d result bytes, %0d of them errors.",
               n_req, n_strings, n_checked, n_err_results);
      if (errors == 0) begin
         $display("tb_json_string_unescape_utf8_top: done, clean");
      end else begin
         $display("tb_json_string_unescape_utf8_top: done, errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/jsu_pkg.sv
hdl/jsu_if.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf8_top.sv
test/tb_json_string_unescape_utf8_top.sv
